// ===== sv/ddo_pkg.sv =====
// Shared types, constants and the arctangent table for the odometry block.
package ddo_pkg;

  localparam int RingDepthDefault   = 5;
  localparam int CordicStepsDefault = 16;

  localparam logic signed [31:0] KinvQ30 = 32'sd652032874;

  localparam logic [31:0] RightScaleReset = 32'd16777216;
  localparam logic [31:0] LeftScaleReset  = 32'd16777216;
  localparam logic [31:0] TurnGainReset   = 32'd0;
  localparam logic [15:0] SampleRateReset = 16'd100;

  typedef enum logic [1:0] {
    REG_RIGHT_SCALE = 2'd0,
    REG_LEFT_SCALE  = 2'd1,
    REG_TURN_GAIN   = 2'd2,
    REG_SAMPLE_RATE = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_R,
    OP_MUL_L,
    OP_STEP,
    OP_RING,
    OP_AVG,
    OP_AVG2,
    OP_AVG3,
    OP_HEAD,
    OP_HACC,
    OP_CINIT,
    OP_CITER,
    OP_POS,
    OP_SPD_T,
    OP_SPD_R,
    OP_SPD_L
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [4:0] iter;
  } dp_cmd_t;

  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'd536870912;  5'd1: r = 32'd316933406;
      5'd2: r = 32'd167458907;  5'd3: r = 32'd85004756;
      5'd4: r = 32'd42667331;   5'd5: r = 32'd21354465;
      5'd6: r = 32'd10679838;   5'd7: r = 32'd5340245;
      5'd8: r = 32'd2670163;    5'd9: r = 32'd1335087;
      5'd10: r = 32'd667544;    5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;    5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;     5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;     5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;       5'd21: r = 32'd326;
      5'd22: r = 32'd163;       5'd23: r = 32'd81;
      5'd24: r = 32'd41;        5'd25: r = 32'd20;
      5'd26: r = 32'd10;        5'd27: r = 32'd5;
      5'd28: r = 32'd3;         5'd29: r = 32'd1;
      5'd30: r = 32'd1;         default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== sv/ddo_ctrl.sv =====
// Sequencing state machine that steps the odometry datapath through one sample.
module ddo_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             load_o,
  output logic             pub_o,
  output ddo_pkg::dp_cmd_t cmd_o
);
  import ddo_pkg::*;

  parameter int CordicSteps = CordicStepsDefault;

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DONE} state_e;

  state_e     state_q;
  op_e        op_q;
  logic [4:0] iter_q;
  logic       out_valid_q;

  localparam logic [4:0] LastIter = 5'(CordicSteps - 1);

  assign in_stall_o  = (state_q != S_IDLE);
  assign load_o      = in_valid_i && (state_q == S_IDLE);
  assign pub_o       = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign cmd_o.op    = (state_q == S_RUN) ? op_q : OP_NONE;
  assign cmd_o.iter  = iter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= OP_NONE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_RUN;
            op_q    <= OP_MUL_R;
          end
        end
        S_RUN: begin
          case (op_q)
            OP_MUL_R: op_q <= OP_MUL_L;
            OP_MUL_L: op_q <= OP_STEP;
            OP_STEP:  op_q <= OP_RING;
            OP_RING:  op_q <= OP_AVG;
            OP_AVG:   op_q <= OP_AVG2;
            OP_AVG2:  op_q <= OP_AVG3;
            OP_AVG3:  op_q <= OP_HEAD;
            OP_HEAD:  op_q <= OP_HACC;
            OP_HACC:  op_q <= OP_CINIT;
            OP_CINIT: begin
              op_q   <= OP_CITER;
              iter_q <= '0;
            end
            OP_CITER: begin
              if (iter_q == LastIter) begin
                op_q <= OP_POS;
              end else begin
                iter_q <= iter_q + 5'd1;
              end
            end
            OP_POS:   op_q <= OP_SPD_T;
            OP_SPD_T: op_q <= OP_SPD_R;
            OP_SPD_R: op_q <= OP_SPD_L;
            default: begin
              op_q    <= OP_NONE;
              state_q <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== sv/ddo_dp.sv =====
// Odometry datapath: scaling, moving-average rings, heading and CORDIC position update.
module ddo_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  ddo_pkg::dp_cmd_t    cmd_i,
  input  logic                pub_i,
  input  logic signed [31:0]  right_count_i,
  input  logic signed [31:0]  left_count_i,
  input  logic signed [31:0]  right_scale_i,
  input  logic signed [31:0]  left_scale_i,
  input  logic [31:0]         turn_gain_i,
  input  logic [15:0]         sample_rate_i,
  output logic signed [47:0]  pos_x_o,
  output logic signed [47:0]  pos_y_o,
  output logic [31:0]         heading_o,
  output logic signed [31:0]  heading_step_o,
  output logic signed [31:0]  travel_o,
  output logic signed [47:0]  robot_speed_o,
  output logic signed [47:0]  right_speed_o,
  output logic signed [47:0]  left_speed_o
);
  import ddo_pkg::*;

  parameter int RingDepth = RingDepthDefault;

  localparam int PosW = (RingDepth > 1) ? $clog2(RingDepth) : 1;
  localparam int SumW = 32 + PosW + 1;
  localparam logic [PosW-1:0] LastPos = PosW'(RingDepth - 1);

  // The ring average divides the sum magnitude in two chunks by reciprocal multiplication.
  localparam int MagW       = SumW - 1;
  localparam int LoW        = 18;
  localparam int HiW        = MagW - LoW;
  localparam int RemW       = 4;
  localparam int ChunkW     = RemW + LoW;
  localparam int RecipShift = ChunkW + 4;
  localparam int RecipW     = RecipShift + 1;
  localparam int ProdW      = ChunkW + RecipW;
  localparam longint RecipL = ((longint'(1) << RecipShift) + RingDepth - 1) / RingDepth;
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipL);

  function automatic logic [MagW-1:0] mag_of(input logic signed [SumW-1:0] s);
    logic [SumW-1:0] a;
    a = s[SumW-1] ? -s : s;
    return a[MagW-1:0];
  endfunction

  function automatic logic [ChunkW-1:0] recip_div(input logic [ChunkW-1:0] x);
    logic [ProdW-1:0] p;
    p = ProdW'(x) * ProdW'(Recip);
    return p[RecipShift +: ChunkW];
  endfunction

  function automatic logic [RemW-1:0] rem_of(input logic [HiW-1:0] h,
      input logic [HiW-1:0] q);
    logic [HiW-1:0] r;
    r = h - q * HiW'(RingDepth);
    return r[RemW-1:0];
  endfunction

  function automatic logic signed [31:0] avg_of(input logic neg,
      input logic [HiW-1:0] qa, input logic [ChunkW-1:0] t);
    logic [ChunkW-1:0] qt;
    logic [MagW-1:0]   q;
    qt = recip_div(t);
    q  = {qa, qt[LoW-1:0]};
    return neg ? -32'(q) : 32'(q);
  endfunction

  logic signed [31:0] rcnt_q, lcnt_q;
  logic signed [63:0] prod_q;
  logic [47:0]        rdist_q, last_r_q, last_l_q;
  logic signed [31:0] sr_q, sl_q;
  logic signed [31:0] rring_q [RingDepth];
  logic signed [31:0] lring_q [RingDepth];
  logic [PosW-1:0]    pos_q;
  logic signed [SumW-1:0] rsum_q, lsum_q;
  logic               rneg_q, lneg_q;
  logic [HiW-1:0]     rhi_q, lhi_q, rqa_q, lqa_q;
  logic [LoW-1:0]     rlo_q, llo_q;
  logic [ChunkW-1:0]  rt_q, lt_q;
  logic signed [31:0] avgr_q, avgl_q;
  logic [31:0]        hstep_q, head_q;
  logic signed [31:0] trav_q;
  logic signed [63:0] cx_q, cy_q;
  logic signed [32:0] cz_q;
  logic [47:0]        xacc_q, yacc_q;
  logic signed [47:0] spd_t_q, spd_r_q, spd_l_q;

  logic [31:0] ang;
  logic        flip;
  logic signed [32:0] trav_cin;
  assign flip = (head_q[31:30] == 2'd1) || (head_q[31:30] == 2'd2);
  assign ang  = flip ? head_q - 32'h8000_0000 : head_q;
  assign trav_cin = 33'(trav_q);

  // Shared multiplier: one 33x33 signed product per cycle, chosen by the current operation.
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.op)
      OP_MUL_R: begin ma = 33'(rcnt_q); mb = 33'(right_scale_i); end
      OP_MUL_L: begin ma = 33'(lcnt_q); mb = 33'(left_scale_i); end
      OP_HEAD: begin
        ma = 33'(avgr_q) - 33'(avgl_q);
        mb = $signed({1'b0, turn_gain_i});
      end
      OP_CINIT: begin ma = flip ? -trav_cin : trav_cin; mb = 33'(KinvQ30); end
      OP_SPD_T: begin ma = 33'(trav_q); mb = $signed({17'd0, sample_rate_i}); end
      OP_SPD_R: begin ma = 33'(sr_q); mb = $signed({17'd0, sample_rate_i}); end
      OP_SPD_L: begin ma = 33'(sl_q); mb = $signed({17'd0, sample_rate_i}); end
      default: ;
    endcase
    mp = ma * mb;
  end

  logic [47:0] dist_w;
  assign dist_w = prod_q[55:8];

  logic signed [SumW-1:0] rsum_n, lsum_n;
  assign rsum_n = rsum_q + SumW'(sr_q) - SumW'(rring_q[pos_q]);
  assign lsum_n = lsum_q + SumW'(sl_q) - SumW'(lring_q[pos_q]);

  logic [MagW-1:0] rmag_w, lmag_w;
  assign rmag_w = mag_of(rsum_q);
  assign lmag_w = mag_of(lsum_q);

  logic signed [32:0] avsum;
  assign avsum = 33'(avgr_q) + 33'(avgl_q);

  logic signed [63:0] xs, ys;
  logic [31:0] atan_w;
  assign xs     = cx_q >>> cmd_i.iter;
  assign ys     = cy_q >>> cmd_i.iter;
  assign atan_w = atan_lut(cmd_i.iter);

  logic signed [47:0] cxf, cyf;
  assign cxf = 48'(cx_q >>> 16);
  assign cyf = 48'(cy_q >>> 16);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_r_q <= '0;
      last_l_q <= '0;
      for (int i = 0; i < RingDepth; i++) begin
        rring_q[i] <= '0;
        lring_q[i] <= '0;
      end
      pos_q  <= '0;
      rsum_q <= '0;
      lsum_q <= '0;
      head_q <= '0;
      xacc_q <= '0;
      yacc_q <= '0;
    end else begin
      if (load_i) begin
        rcnt_q <= right_count_i;
        lcnt_q <= left_count_i;
      end
      case (cmd_i.op)
        OP_MUL_R: prod_q <= 64'(mp);
        OP_MUL_L: begin
          rdist_q <= dist_w;
          prod_q  <= 64'(mp);
        end
        OP_STEP: begin
          sr_q     <= 32'(rdist_q - last_r_q);
          sl_q     <= 32'(dist_w - last_l_q);
          last_r_q <= rdist_q;
          last_l_q <= dist_w;
        end
        OP_RING: begin
          rsum_q <= rsum_n;
          lsum_q <= lsum_n;
          rring_q[pos_q] <= sr_q;
          lring_q[pos_q] <= sl_q;
          pos_q <= (pos_q == LastPos) ? '0 : pos_q + PosW'(1);
        end
        OP_AVG: begin
          rneg_q <= rsum_q[SumW-1];
          lneg_q <= lsum_q[SumW-1];
          rhi_q  <= rmag_w[MagW-1:LoW];
          lhi_q  <= lmag_w[MagW-1:LoW];
          rlo_q  <= rmag_w[LoW-1:0];
          llo_q  <= lmag_w[LoW-1:0];
          rqa_q  <= HiW'(recip_div(ChunkW'(rmag_w[MagW-1:LoW])));
          lqa_q  <= HiW'(recip_div(ChunkW'(lmag_w[MagW-1:LoW])));
        end
        OP_AVG2: begin
          rt_q <= {rem_of(rhi_q, rqa_q), rlo_q};
          lt_q <= {rem_of(lhi_q, lqa_q), llo_q};
        end
        OP_AVG3: begin
          avgr_q <= avg_of(rneg_q, rqa_q, rt_q);
          avgl_q <= avg_of(lneg_q, lqa_q, lt_q);
        end
        OP_HEAD: begin
          hstep_q <= mp[47:16];
          trav_q  <= 32'(avsum >>> 1);
        end
        OP_HACC: head_q <= head_q + hstep_q;
        OP_CINIT: begin
          cx_q <= 64'(mp) >>> 14;
          cy_q <= '0;
          cz_q <= 33'($signed(ang));
        end
        OP_CITER: begin
          if (!cz_q[32]) begin
            cx_q <= cx_q - ys;
            cy_q <= cy_q + xs;
            cz_q <= cz_q - $signed({1'b0, atan_w});
          end else begin
            cx_q <= cx_q + ys;
            cy_q <= cy_q - xs;
            cz_q <= cz_q + $signed({1'b0, atan_w});
          end
        end
        OP_POS: begin
          xacc_q <= xacc_q - cxf;
          yacc_q <= yacc_q - cyf;
        end
        OP_SPD_T: spd_t_q <= 48'(mp);
        OP_SPD_R: spd_r_q <= 48'(mp);
        OP_SPD_L: spd_l_q <= 48'(mp);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (pub_i) begin
      pos_x_o        <= xacc_q;
      pos_y_o        <= yacc_q;
      heading_o      <= head_q;
      heading_step_o <= hstep_q;
      travel_o       <= trav_q;
      robot_speed_o  <= spd_t_q;
      right_speed_o  <= spd_r_q;
      left_speed_o   <= spd_l_q;
    end
  end
endmodule

// ===== sv/diff_drive_odometry_top.sv =====
// Top level of the differential drive odometry block.
//  channel | handshake             | payload
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in_valid_i/in_stall_o | right_count_i, left_count_i
//  out     | out_valid_o/out_stall_i | pos, heading, travel, speeds
// Samples are taken one at a time and run an iterative CORDIC (16
// iterations by default) sharing one 33x33 multiplier.
// Reset clears position, heading, distances and both averaging rings at once.
// A result waits in the output register while the next transaction is taken.
module diff_drive_odometry_top #(
  parameter int RingDepth   = ddo_pkg::RingDepthDefault,
  parameter int CordicSteps = ddo_pkg::CordicStepsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] right_count_i,
  input  logic signed [31:0] left_count_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [47:0] pos_x_o,
  output logic signed [47:0] pos_y_o,
  output logic [31:0]        heading_o,
  output logic signed [31:0] heading_step_o,
  output logic signed [31:0] travel_o,
  output logic signed [47:0] robot_speed_o,
  output logic signed [47:0] right_speed_o,
  output logic signed [47:0] left_speed_o
);
  import ddo_pkg::*;

  logic [31:0] rscale_q, lscale_q, gain_q;
  logic [15:0] rate_q;
  logic        load;
  dp_cmd_t     cmd;
  logic        pub;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rscale_q <= RightScaleReset;
      lscale_q <= LeftScaleReset;
      gain_q   <= TurnGainReset;
      rate_q   <= SampleRateReset;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_RIGHT_SCALE: rscale_q <= cfg_data_i;
        REG_LEFT_SCALE:  lscale_q <= cfg_data_i;
        REG_TURN_GAIN:   gain_q   <= cfg_data_i;
        REG_SAMPLE_RATE: rate_q   <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  ddo_ctrl #(.CordicSteps(CordicSteps)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .load_o(load), .pub_o(pub), .cmd_o(cmd)
  );

  ddo_dp #(.RingDepth(RingDepth)) u_dp (
    .clk_i, .rst_ni, .load_i(load), .cmd_i(cmd), .pub_i(pub),
    .right_count_i, .left_count_i,
    .right_scale_i(rscale_q), .left_scale_i(lscale_q),
    .turn_gain_i(gain_q), .sample_rate_i(rate_q),
    .pos_x_o, .pos_y_o, .heading_o, .heading_step_o, .travel_o,
    .robot_speed_o, .right_speed_o, .left_speed_o
  );
endmodule
